// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the sampler voice.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/lsvp_pkg.sv -----
`timescale 1ns / 1ps
// Package of the sampler voice: request and result types, codes and constants.
// Used by the sample memory, the shared arithmetic unit and the top level.
package lsvp_pkg;

  localparam int POS_W = 40;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_FRAME   = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  localparam logic [1:0] LOOP_OFF  = 2'd0;
  localparam logic [1:0] LOOP_FWD  = 2'd1;
  localparam logic [1:0] LOOP_PING = 2'd2;

  localparam logic [2:0] CFG_LOOP_MODE    = 3'd0;
  localparam logic [2:0] CFG_LOOP_BEGIN   = 3'd1;
  localparam logic [2:0] CFG_LOOP_STOP    = 3'd2;
  localparam logic [2:0] CFG_SAMPLE_LEN   = 3'd3;
  localparam logic [2:0] CFG_WIDTH_MODE   = 3'd4;
  localparam logic [2:0] CFG_STEP         = 3'd5;

  localparam logic [16:0] FULL_SCALE = 17'h10000;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        address;
    logic signed [15:0] sample_word;
  } voice_in_t;

  typedef struct packed {
    logic signed [15:0] frame_value;
    logic               voice_active;
  } voice_out_t;

  typedef enum logic {
    OP_MAC,
    OP_REM
  } unit_op_t;

  typedef struct packed {
    unit_op_t           op;
    logic signed [17:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] acc;
    logic [16:0]        rem;
    logic               rem_bit;
    logic [16:0]        divisor;
  } unit_req_t;

endpackage

// ----- src/lsvp_sample_mem.sv -----
`timescale 1ns / 1ps
// Sample memory of the sampler voice with a registered read port.
// Decodes eight-bit and sixteen-bit samples; depends on lsvp_pkg.
module lsvp_sample_mem #(
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [15:0]        wr_addr,
  input  logic [15:0]        wr_data,
  input  logic               rd_en,
  input  logic [15:0]        rd_addr,
  input  logic               width_mode,
  output logic signed [15:0] rd_sample
);
  import lsvp_pkg::*;

  localparam int AW   = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int EXTW = (AW > 16) ? AW : 16;

  logic [15:0]     mem [SAMPLE_DEPTH];
  logic [EXTW-1:0] wr_ext;
  logic [EXTW-1:0] rd_ext;
  logic            wr_in_range;
  logic            rd_in_range;
  logic [15:0]     rd_word_r;
  logic            rd_oob_r;

  assign wr_ext      = EXTW'(wr_addr);
  assign rd_ext      = EXTW'(rd_addr);
  assign wr_in_range = 32'(wr_addr) < 32'(SAMPLE_DEPTH);
  assign rd_in_range = 32'(rd_addr) < 32'(SAMPLE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en && wr_in_range) begin
      mem[wr_ext[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_oob_r <= !rd_in_range;
      if (rd_in_range) begin
        rd_word_r <= mem[rd_ext[AW-1:0]];
      end
    end
  end

  always_comb begin
    if (rd_oob_r) begin
      rd_sample = '0;
    end else if (width_mode) begin
      rd_sample = rd_word_r;
    end else begin
      rd_sample = {rd_word_r[7:0], 8'h00};
    end
  end

endmodule

// ----- src/lsvp_unit.sv -----
`timescale 1ns / 1ps
// Shared arithmetic unit: multiply-accumulate and one restoring remainder step.
// Depends on lsvp_pkg for the request type.
module lsvp_unit (
  input  lsvp_pkg::unit_req_t req,
  output logic signed [35:0]  mac_res,
  output logic [16:0]         rem_res
);
  import lsvp_pkg::*;

  logic signed [35:0] product;
  logic [17:0]        shifted;
  logic [17:0]        diff;

  assign product = req.mul_a * req.mul_b;
  assign shifted = {req.rem, req.rem_bit};
  assign diff    = shifted - {1'b0, req.divisor};

  always_comb begin
    mac_res = '0;
    rem_res = '0;
    unique case (req.op)
      OP_MAC: begin
        mac_res = req.acc + product;
      end
      OP_REM: begin
        if (shifted >= {1'b0, req.divisor}) begin
          rem_res = diff[16:0];
        end else begin
          rem_res = shifted[16:0];
        end
      end
      default: begin
        mac_res = '0;
      end
    endcase
  end

endmodule

// ----- src/looped_sample_voice_player_top.sv -----
`timescale 1ns / 1ps
// Sampler voice that plays looped samples with linear interpolation.
// Uses lsvp_pkg, lsvp_sample_mem, lsvp_unit and assert_macros.svh.
//
// A sample write or a restart request is taken in S_IDLE. A frame request on a
// playing voice passes through S_SETUP, S_RD_NXT, S_MAC, S_ADV and S_DONE when
// the new position needs no folding into the loop. It adds S_MOD and S_FOLD when
// the position wraps past the loop end, because the wrap is a 40-bit remainder
// worked out one bit per cycle in the shared arithmetic unit. The same unit
// also does the two multiply-accumulate steps of the interpolation. A frame on
// an inactive voice, or on one already past the sample end, goes from S_SETUP
// straight to S_DONE. A frame waits in S_DONE while the output register holds an
// earlier result that is stalled. A finished frame waits in the output register
// while write and restart requests go on being taken.
module looped_sample_voice_player_top #(
  parameter int SAMPLE_DEPTH = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lsvp_pkg::voice_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lsvp_pkg::voice_out_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  import lsvp_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_RD_NXT,
    S_MAC,
    S_ADV,
    S_MOD,
    S_FOLD,
    S_DONE
  } state_t;

  state_t state_r;

  logic [1:0]  loop_mode_r;
  logic [15:0] loop_begin_r;
  logic [16:0] loop_stop_r;
  logic [16:0] sample_length_r;
  logic        width_mode_r;
  logic [31:0] step_r;

  logic [POS_W-1:0] pos_r;
  logic [15:0]      frac_r;
  logic [15:0]      ri_r;
  logic [15:0]      rf_r;
  logic             backward_r;
  logic             playing_r;

  logic [1:0]         mode_r;
  logic [15:0]        nxt_r;
  logic               has_next_r;
  logic [16:0]        mix_r;
  logic signed [35:0] acc_r;
  logic [POS_W-1:0]   dividend_r;
  logic [16:0]        rem_r;
  logic [16:0]        div_r;
  logic [5:0]         cnt_r;
  logic [15:0]        val_r;
  logic               active_r;
  logic               out_valid_r;
  voice_out_t         out_data_r;

  logic               accept;
  logic               mem_wr_en;
  logic               mem_rd_en;
  logic [15:0]        mem_rd_addr;
  logic signed [15:0] sample;
  unit_req_t          req;
  logic signed [35:0] mac_res;
  logic [16:0]        rem_res;

  logic [16:0]        len;
  logic [1:0]         mode_eff;
  logic [16:0]        ri17;
  logic [16:0]        ri_p1;
  logic [16:0]        lb17;
  logic [16:0]        lb_p1;
  logic [16:0]        lim;
  logic               fwd;
  logic [16:0]        nxt_c;
  logic               has_next_c;
  logic [16:0]        mix_c;
  logic signed [35:0] acc_rnd;
  logic signed [19:0] rnd;
  logic [15:0]        val_c;
  logic [16:0]        total;
  logic [POS_W-1:0]   pos_new;
  logic [16:0]        span;
  logic [17:0]        span2;
  logic [17:0]        fold_v;
  logic [16:0]        ls_m1;
  logic [17:0]        fold_back;

  assign cfg_ready = 1'b1;
  assign in_stall  = state_r != S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_mode_r     <= LOOP_OFF;
      loop_begin_r    <= '0;
      loop_stop_r     <= '0;
      sample_length_r <= '0;
      width_mode_r    <= 1'b1;
      step_r          <= 32'h0001_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOOP_MODE:  loop_mode_r     <= cfg_data[1:0];
        CFG_LOOP_BEGIN: loop_begin_r    <= cfg_data[15:0];
        CFG_LOOP_STOP:  loop_stop_r     <= cfg_data[16:0];
        CFG_SAMPLE_LEN: sample_length_r <= cfg_data[16:0];
        CFG_WIDTH_MODE: width_mode_r    <= cfg_data[0];
        CFG_STEP:       step_r          <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign mem_wr_en   = accept && in_data.action == ACT_WRITE;
  assign mem_rd_en   = state_r == S_SETUP || state_r == S_RD_NXT;
  assign mem_rd_addr = (state_r == S_SETUP) ? ri_r : nxt_r;

  lsvp_sample_mem #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (in_data.address),
    .wr_data   (in_data.sample_word),
    .rd_en     (mem_rd_en),
    .rd_addr   (mem_rd_addr),
    .width_mode(width_mode_r),
    .rd_sample (sample)
  );

  always_comb begin
    req         = '0;
    req.op      = OP_MAC;
    req.rem     = rem_r;
    req.rem_bit = dividend_r[POS_W-1];
    req.divisor = div_r;
    unique case (state_r)
      S_RD_NXT: begin
        req.mul_a = 18'(sample);
        req.mul_b = {1'b0, FULL_SCALE - mix_r};
      end
      S_MAC: begin
        req.mul_a = has_next_r ? 18'(sample) : '0;
        req.mul_b = {1'b0, mix_r};
        req.acc   = acc_r;
      end
      S_MOD: begin
        req.op = OP_REM;
      end
      default: begin
        req.acc = '0;
      end
    endcase
  end

  lsvp_unit u_unit (
    .req    (req),
    .mac_res(mac_res),
    .rem_res(rem_res)
  );

  assign len  = (sample_length_r > FULL_SCALE) ? FULL_SCALE : sample_length_r;
  assign ri17 = {1'b0, ri_r};
  assign lb17 = {1'b0, loop_begin_r};
  assign ri_p1 = ri17 + 17'd1;
  assign lb_p1 = lb17 + 17'd1;

  always_comb begin
    if (loop_mode_r == 2'd3 || lb17 >= loop_stop_r || loop_stop_r > len) begin
      mode_eff = LOOP_OFF;
    end else begin
      mode_eff = loop_mode_r;
    end
  end

  assign fwd = !backward_r || mode_eff != LOOP_PING;
  assign lim = (mode_eff != LOOP_OFF) ? loop_stop_r : len;

  always_comb begin
    has_next_c = 1'b1;
    nxt_c      = '0;
    if (fwd) begin
      if (ri_p1 < lim) begin
        nxt_c = ri_p1;
      end else if (mode_eff == LOOP_FWD) begin
        nxt_c = lb17;
      end else if (mode_eff == LOOP_PING) begin
        nxt_c = (ri17 > lb17) ? ri17 - 17'd1 : lb17;
      end else begin
        has_next_c = 1'b0;
      end
    end else if (lb_p1 == loop_stop_r) begin
      nxt_c = lb17;
    end else begin
      nxt_c = (ri17 > lb17) ? ri17 - 17'd1 : lb_p1;
      if (nxt_c >= loop_stop_r) begin
        nxt_c = loop_stop_r - 17'd1;
      end
    end
  end

  assign mix_c = (nxt_c < ri17) ? FULL_SCALE - {1'b0, rf_r} : {1'b0, rf_r};

  assign acc_rnd = acc_r + 36'sd32768;
  assign rnd     = 20'(acc_rnd >>> 16);

  always_comb begin
    if (rnd > 20'sd32767) begin
      val_c = 16'h7FFF;
    end else if (rnd < -20'sd32768) begin
      val_c = 16'h8000;
    end else begin
      val_c = rnd[15:0];
    end
  end

  assign total   = {1'b0, frac_r} + {1'b0, step_r[15:0]};
  assign pos_new = pos_r + POS_W'(step_r[31:16]) + POS_W'(total[16]);
  assign span    = loop_stop_r - lb17;
  assign span2   = {span, 1'b0} - 18'd2;
  assign fold_v  = {1'b0, rem_r} + {2'b00, loop_begin_r};
  assign ls_m1   = loop_stop_r - 17'd1;
  assign fold_back = {ls_m1, 1'b0} - fold_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      frac_r      <= '0;
      ri_r        <= '0;
      rf_r        <= '0;
      backward_r  <= 1'b0;
      playing_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_data.action == ACT_RESTART) begin
              pos_r      <= '0;
              frac_r     <= '0;
              ri_r       <= '0;
              rf_r       <= '0;
              backward_r <= 1'b0;
              playing_r  <= 1'b1;
            end else if (in_data.action == ACT_FRAME) begin
              state_r <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          val_r    <= '0;
          active_r <= 1'b0;
          if (!playing_r) begin
            state_r <= S_DONE;
          end else if (ri17 >= len) begin
            playing_r <= 1'b0;
            state_r   <= S_DONE;
          end else begin
            mode_r     <= mode_eff;
            nxt_r      <= nxt_c[15:0];
            has_next_r <= has_next_c;
            mix_r      <= mix_c;
            state_r    <= S_RD_NXT;
          end
        end
        S_RD_NXT: begin
          acc_r   <= mac_res;
          state_r <= S_MAC;
        end
        S_MAC: begin
          acc_r   <= mac_res;
          state_r <= S_ADV;
        end
        S_ADV: begin
          val_r    <= val_c;
          active_r <= 1'b1;
          pos_r    <= pos_new;
          frac_r   <= total[15:0];
          state_r  <= S_DONE;
          if (mode_r == LOOP_OFF) begin
            if (pos_new >= POS_W'(len)) begin
              playing_r <= 1'b0;
              active_r  <= 1'b0;
            end else begin
              ri_r <= pos_new[15:0];
              rf_r <= total[15:0];
            end
          end else if (pos_new < POS_W'(loop_stop_r)) begin
            backward_r <= 1'b0;
            ri_r       <= pos_new[15:0];
            rf_r       <= total[15:0];
          end else if (lb_p1 == loop_stop_r) begin
            backward_r <= 1'b0;
            ri_r       <= loop_begin_r;
            rf_r       <= '0;
          end else begin
            dividend_r <= pos_new - POS_W'(loop_begin_r);
            div_r      <= (mode_r == LOOP_FWD) ? span : span2[16:0];
            rem_r      <= '0;
            cnt_r      <= '0;
            state_r    <= S_MOD;
          end
        end
        S_MOD: begin
          rem_r      <= rem_res;
          dividend_r <= dividend_r << 1;
          cnt_r      <= cnt_r + 6'd1;
          if (cnt_r == 6'(POS_W - 1)) begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          state_r <= S_DONE;
          if (mode_r == LOOP_FWD || fold_v < {1'b0, ls_m1}) begin
            backward_r <= 1'b0;
            ri_r       <= fold_v[15:0];
            rf_r       <= frac_r;
          end else begin
            backward_r <= 1'b1;
            if (fold_back > {2'b00, loop_begin_r} && frac_r != 16'd0) begin
              ri_r <= fold_back[15:0] - 16'd1;
              rf_r <= 16'd0 - frac_r;
            end else begin
              ri_r <= fold_back[15:0];
              rf_r <= frac_r;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r             <= 1'b1;
            out_data_r.frame_value  <= val_r;
            out_data_r.voice_active <= active_r;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_rem_bound, state_r != S_MOD || rem_r < div_r, "remainder exceeds loop span")
  `ASSERT_NEXT(a_out_from_done, !out_valid_r, !out_valid_r || $past(state_r) == S_DONE, "output without frame")
  `ASSERT_NEXT(a_frame_setup, accept && in_data.action == ACT_FRAME, state_r == S_SETUP, "frame request lost")

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for looped_sample_voice_player_top: sample writes, restarts and
// frames are predicted bit for bit and each frame result is compared in order.
// Depends on lsvp_pkg and the RTL of the sampler voice.
module testbench;
  import lsvp_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic W8 = 1'b0;
  localparam logic W16 = 1'b1;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  voice_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  voice_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  looped_sample_voice_player_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  voice_in_t request_queue[$];
  voice_out_t frame_queue[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit drain_each = 1'b0;
  bit in_took = 1'b0;
  int errors = 0;
  int quiet_cycles = 0;

  logic [15:0] smem [0:65535];
  logic [39:0] play_pos;
  longint play_frac, rd_index, rd_frac;
  bit backward, playing;
  longint c_mode, c_begin, c_stop, c_len, c_width;
  logic [31:0] c_step;

  function automatic longint sample_at(longint idx);
    logic [15:0] w;
    longint b;
    if (idx >= 65536) return 0;
    w = smem[idx[15:0]];
    if (c_width == W8) begin
      b = $signed(w[7:0]);
      return b * 256;
    end
    b = $signed(w);
    return b;
  endfunction

  function automatic voice_out_t voice_frame();
    voice_out_t r;
    longint len, m, nxt, mix, lim, cur, nv, acc, val, span, lmod, v, back, p;
    bit has_next;
    logic [16:0] total;
    r = '0;
    if (!playing) return r;
    len = (c_len > 65536) ? 65536 : c_len;
    if (rd_index >= len) begin
      playing = 1'b0;
      return r;
    end
    m = c_mode;
    if (m > LOOP_PING || c_begin >= c_stop || c_stop > len) m = LOOP_OFF;
    has_next = 1'b0;
    nxt = 0;
    if (!backward || m != LOOP_PING) begin
      lim = (m != LOOP_OFF) ? c_stop : len;
      if (rd_index + 1 < lim) begin
        has_next = 1'b1;
        nxt = rd_index + 1;
      end else if (m == LOOP_FWD) begin
        has_next = 1'b1;
        nxt = c_begin;
      end else if (m == LOOP_PING) begin
        has_next = 1'b1;
        nxt = (rd_index > c_begin) ? rd_index - 1 : c_begin;
      end
    end else if (c_begin + 1 == c_stop) begin
      has_next = 1'b1;
      nxt = c_begin;
    end else begin
      has_next = 1'b1;
      nxt = (rd_index > c_begin) ? rd_index - 1 : c_begin + 1;
      if (nxt >= c_stop) nxt = c_stop - 1;
    end
    mix = (nxt < rd_index) ? 65536 - rd_frac : rd_frac;
    cur = sample_at(rd_index);
    nv = has_next ? sample_at(nxt) : 0;
    acc = cur * (65536 - mix) + nv * mix;
    val = (acc + 32768) >>> 16;
    if (val > 32767) val = 32767;
    if (val < -32768) val = -32768;
    r.frame_value = val[15:0];

    total = {1'b0, play_frac[15:0]} + {1'b0, c_step[15:0]};
    play_pos = play_pos + c_step[31:16] + total[16];
    play_frac = total[15:0];
    p = longint'(play_pos);
    if (m == LOOP_OFF) begin
      if (p >= len) begin
        playing = 1'b0;
        return r;
      end
      rd_index = p;
      rd_frac = play_frac;
    end else if (p < c_stop) begin
      backward = 1'b0;
      rd_index = p;
      rd_frac = play_frac;
    end else if (c_begin + 1 == c_stop) begin
      backward = 1'b0;
      rd_index = c_begin;
      rd_frac = 0;
    end else begin
      span = c_stop - c_begin;
      lmod = (m == LOOP_FWD) ? span : 2 * span - 2;
      v = (p - c_begin) % lmod + c_begin;
      if (m == LOOP_FWD || v < c_stop - 1) begin
        backward = 1'b0;
        rd_index = v;
        rd_frac = play_frac;
      end else begin
        back = v - (c_stop - 1);
        backward = 1'b1;
        rd_index = c_stop - 1 - back;
        rd_frac = play_frac;
        if (rd_index > c_begin && rd_frac > 0) begin
          rd_index = rd_index - 1;
          rd_frac = 65536 - rd_frac;
        end
      end
    end
    r.voice_active = 1'b1;
    return r;
  endfunction

  task automatic apply_request(voice_in_t q);
    case (q.action)
      ACT_WRITE: smem[q.address] = q.sample_word;
      ACT_RESTART: begin
        play_pos = '0;
        play_frac = 0;
        rd_index = 0;
        rd_frac = 0;
        backward = 1'b0;
        playing = 1'b1;
      end
      ACT_FRAME: frame_queue.push_back(voice_frame());
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
    if (!in_valid || in_took) begin
      in_took = 1'b0;
      if (request_queue.size() > 0 && !(drain_each && frame_queue.size() > 0) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= request_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      bit progress;
      voice_out_t e;
      progress = 1'b0;
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        apply_request(in_data);
        progress = 1'b1;
      end
      if (out_valid && !out_stall) begin
        progress = 1'b1;
        if (frame_queue.size() == 0) begin
          errors++;
          $display("%0t: unexpected frame, expected none, actual %0d/%0b", $time,
                   out_data.frame_value, out_data.voice_active);
        end else begin
          e = frame_queue.pop_front();
          if (e.frame_value !== out_data.frame_value) begin
            errors++;
            $display("%0t: frame_value mismatch, expected %0d, actual %0d", $time,
                     e.frame_value, out_data.frame_value);
          end
          if (e.voice_active !== out_data.voice_active) begin
            errors++;
            $display("%0t: voice_active mismatch, expected %0b, actual %0b", $time,
                     e.voice_active, out_data.voice_active);
          end
        end
      end
      if (cfg_valid && cfg_ready) progress = 1'b1;
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** looped_sample_voice_player_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LOOP_MODE: c_mode = val[1:0];
      CFG_LOOP_BEGIN: c_begin = val[15:0];
      CFG_LOOP_STOP: c_stop = val[16:0];
      CFG_SAMPLE_LEN: c_len = val[16:0];
      CFG_WIDTH_MODE: c_width = val[0];
      CFG_STEP: c_step = val;
      default: ;
    endcase
  endtask

  task automatic set_voice(logic [1:0] m, int b, int s, int len, logic w, logic [31:0] st);
    write_reg(CFG_LOOP_MODE, m);
    write_reg(CFG_LOOP_BEGIN, b);
    write_reg(CFG_LOOP_STOP, s);
    write_reg(CFG_SAMPLE_LEN, len);
    write_reg(CFG_WIDTH_MODE, w);
    write_reg(CFG_STEP, st);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push(logic [1:0] act, logic [15:0] addr, logic [15:0] word);
    voice_in_t q;
    q.action = act;
    q.address = addr;
    q.sample_word = word;
    request_queue.push_back(q);
  endtask

  task automatic wait_idle();
    while (request_queue.size() > 0 || in_valid || frame_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 7))
      0: return 32'h10000;
      1: return $urandom_range(0, 255);
      2: return $urandom;
      3: return 32'hFFFFFFFF;
      default: return $urandom_range(0, 4 * 65536);
    endcase
  endfunction

  initial begin
    int len, b, s, n;
    logic [1:0] m;
    c_mode = LOOP_OFF; c_begin = 0; c_stop = 0; c_len = 0; c_width = W16; c_step = 32'h10000;
    play_pos = '0; play_frac = 0; rd_index = 0; rd_frac = 0; backward = 0; playing = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    push(ACT_FRAME, 0, 0);
    push(ACT_RESTART, 0, 0);
    push(ACT_FRAME, 0, 0);
    push(ACT_WRITE, 16'd0, 16'h7FFF);
    push(ACT_WRITE, 16'd1, 16'h8000);
    push(ACT_WRITE, 16'hFFFF, 16'hFF80);
    push(ACT_UNUSED, 16'hFFFF, 16'hFFFF);
    wait_idle();
    set_voice(LOOP_OFF, 0, 0, 65536, W16, 32'hFFFFFFFF);
    push(ACT_RESTART, 0, 0);
    repeat (3) push(ACT_FRAME, 0, 0);
    wait_idle();
    set_voice(LOOP_OFF, 0, 0, 17'h1FFFF, W8, 32'hFFFFFFFF);
    push(ACT_RESTART, 0, 0);
    repeat (3) push(ACT_FRAME, 0, 0);
    wait_idle();
    set_voice(LOOP_OFF, 0, 0, 65536, W16, 32'd0);
    push(ACT_RESTART, 0, 0);
    repeat (2) push(ACT_FRAME, 0, 0);
    wait_idle();

    for (int p = 0; p < 12; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 70; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 70; end
        default: begin send_idle_pct = 8; stall_pct = 8; end
      endcase
      drain_each = (p == 5);
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : $urandom_range(2, 48);
      m = $urandom_range(0, 3);
      if ($urandom_range(0, 3) != 0) begin
        b = $urandom_range(0, len - 1);
        s = $urandom_range(b + 1, len);
      end else begin
        b = $urandom_range(0, len + 1);
        s = $urandom_range(0, len + 1);
      end
      set_voice(m, b, s, len, $urandom_range(0, 1), pick_step());
      for (int a = 0; a < len; a++) push(ACT_WRITE, a, $urandom);
      push(ACT_RESTART, 0, 0);
      n = 0;
      while (n < 70) begin
        case ($urandom_range(0, 19))
          0: push(ACT_RESTART, 0, 0);
          1: push(ACT_WRITE, $urandom_range(0, len - 1), $urandom);
          2: push(ACT_WRITE, $urandom_range(len, 65535), $urandom);
          3: push(ACT_UNUSED, $urandom, $urandom);
          default: push(ACT_FRAME, $urandom, $urandom);
        endcase
        n++;
      end
      wait_idle();
    end
    drain_each = 1'b0;

    for (int p = 0; p < 2; p++) begin
      send_idle_pct = 0;
      stall_pct = 8;
      set_voice(p ? LOOP_PING : LOOP_FWD, 0, 2, 2, W16, 32'hFFFFFFFF);
      push(ACT_WRITE, 16'd0, $urandom);
      push(ACT_WRITE, 16'd1, $urandom);
      push(ACT_RESTART, 0, 0);
      repeat (20) push(ACT_FRAME, 0, 0);
      wait_idle();
    end

    if (errors == 0 && frame_queue.size() == 0) begin
      $display("** looped_sample_voice_player_top: PASSED **");
    end else begin
      $display("** looped_sample_voice_player_top: FAILED **");
    end
    $finish;
  end
endmodule
